/* sv/xcr_pkg.sv */
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared types, character codes and the CRC helper function of the
// XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcr_pkg;

    localparam int BLOCK_BYTES_DEF = 128;

    // Serial line characters.
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_PAD = 8'h1A;
    localparam logic [7:0] CH_ERASED = 8'hFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Request operations.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_FLASH = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Final status codes.
    localparam logic [1:0] ST_COMPLETE  = 2'd0;
    localparam logic [1:0] ST_START_ERR = 2'd1;
    localparam logic [1:0] ST_CANCELLED = 2'd2;
    localparam logic [1:0] ST_TIMEOUT   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FLASH_BASE   = 3'd0;
    localparam logic [2:0] CFG_START_WAIT   = 3'd1;
    localparam logic [2:0] CFG_BODY_WAIT    = 3'd2;
    localparam logic [2:0] CFG_PACKET_WAIT  = 3'd3;
    localparam logic [2:0] CFG_TAIL_WAIT    = 3'd4;
    localparam logic [2:0] CFG_START_TRIES  = 3'd5;
    localparam logic [2:0] CFG_PACKET_TRIES = 3'd6;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 112;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BODY,
        PH_PACKET,
        PH_TAIL_EOT,
        PH_TAIL_CAN
    } phase_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_EVAL,
        C_DISPATCH,
        C_SCAN_RD,
        C_SCAN_CHK,
        C_TXA,
        C_WR_RD,
        C_WR_GET,
        C_WR_OUT,
        C_TXB,
        C_TXC,
        C_FIN
    } ctrl_state_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_TXA,
        EM_WORD,
        EM_TXB,
        EM_TXC,
        EM_FIN
    } emit_sel_t;

    // Work plan decided when a request is evaluated.
    typedef struct packed {
        logic       tx_a_en;
        logic [7:0] tx_a;
        logic       wr_en;
        logic       scan_en;
        logic       wr_half;
        logic       tx_b_en;
        logic [7:0] tx_b;
        logic       tx_c_en;
        logic [7:0] tx_c;
        logic       fin_en;
        logic [1:0] fin_status;
    } plan_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic      capture;
        logic      eval;
        logic      scan_rd;
        logic      len_dec;
        logic      wr_rd;
        logic      wr_get;
        logic      total_add;
        emit_sel_t emit;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_en;
        logic tx_a_en;
        logic wr_go;
        logic tx_b_en;
        logic tx_c_en;
        logic fin_en;
        logic len_zero;
        logic rd_pad;
        logic k_last;
        logic w_last;
        logic out_free;
    } dp_status_t;

    // One byte of CRC16-CCITT, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int j = 0; j < 8; j++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/xcr_ram.sv */
// ----------------------------------------------------------------------------
// xcr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module xcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/xcr_ctrl.sv */
// ----------------------------------------------------------------------------
// xcr_ctrl
// Sequencer: takes one request, has it evaluated, then walks the planned
// results (reply bytes, flash words, final status) into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xcr_ctrl
    import xcr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = C_EVAL;
                end
            end
            C_EVAL:     state_next = C_DISPATCH;
            C_DISPATCH: state_next = st.scan_en ? C_SCAN_RD : C_TXA;
            C_SCAN_RD:  state_next = st.len_zero ? C_TXA : C_SCAN_CHK;
            C_SCAN_CHK: state_next = st.rd_pad ? C_SCAN_RD : C_TXA;
            C_TXA:
            begin
                if (!st.tx_a_en || st.out_free)
                begin
                    state_next = st.wr_go ? C_WR_RD : C_TXB;
                end
            end
            C_WR_RD:    state_next = C_WR_GET;
            C_WR_GET:   state_next = st.k_last ? C_WR_OUT : C_WR_RD;
            C_WR_OUT:
            begin
                if (st.out_free)
                begin
                    state_next = st.w_last ? C_TXB : C_WR_RD;
                end
            end
            C_TXB:
            begin
                if (!st.tx_b_en || st.out_free)
                begin
                    state_next = C_TXC;
                end
            end
            C_TXC:
            begin
                if (!st.tx_c_en || st.out_free)
                begin
                    state_next = C_FIN;
                end
            end
            C_FIN:
            begin
                if (!st.fin_en || st.out_free)
                begin
                    state_next = C_IDLE;
                end
            end
            default:    state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.emit = EM_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            C_EVAL:     cmd.eval = 1'b1;
            C_DISPATCH: ;
            C_SCAN_RD:  cmd.scan_rd = !st.len_zero;
            C_SCAN_CHK: cmd.len_dec = st.rd_pad;
            C_TXA:
            begin
                if (st.tx_a_en && st.out_free)
                begin
                    cmd.emit = EM_TXA;
                end
            end
            C_WR_RD:    cmd.wr_rd = 1'b1;
            C_WR_GET:   cmd.wr_get = 1'b1;
            C_WR_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.emit      = EM_WORD;
                    cmd.total_add = st.w_last;
                end
            end
            C_TXB:
            begin
                if (st.tx_b_en && st.out_free)
                begin
                    cmd.emit = EM_TXB;
                end
            end
            C_TXC:
            begin
                if (st.tx_c_en && st.out_free)
                begin
                    cmd.emit = EM_TXC;
                end
            end
            C_FIN:
            begin
                if (st.fin_en && st.out_free)
                begin
                    cmd.emit = EM_FIN;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* sv/xcr_dp.sv */
// ----------------------------------------------------------------------------
// xcr_dp
// Datapath: protocol state, configuration, block store, CRC, trailing pad
// trim, flash word assembly and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xcr_dp
    import xcr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast,
    input  wire dp_cmd_t                cmd,
    output dp_status_t                  st
);

    localparam int WORDS  = (BLOCK_BYTES + 3) / 4;
    localparam int DEPTH  = 2 * BLOCK_BYTES;
    localparam int AW     = $clog2(DEPTH);
    localparam int SUM_W  = AW + 1;
    localparam int BI_W   = $clog2(BLOCK_BYTES + 4);
    localparam int LEN_W  = $clog2(BLOCK_BYTES + 1);
    localparam int WW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int POS_W  = WW + 2;
    localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

    // Configuration registers.
    logic [31:0] flash_base_reg;
    logic [15:0] start_wait_reg, body_wait_reg, packet_wait_reg, tail_wait_reg;
    logic [3:0]  start_tries_reg, packet_tries_reg;

    // Protocol state.
    phase_t            phase_reg, phase_next;
    logic [3:0]        tries_reg, tries_next;
    logic [15:0]       timer_reg, timer_next;
    logic [BI_W-1:0]   bidx_reg, bidx_next;
    logic              from_start_reg, from_start_next;
    logic [7:0]        exp_reg, exp_next;
    logic [7:0]        bnum_reg, bnum_next;
    logic [7:0]        bcomp_reg, bcomp_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       crcrx_reg, crcrx_next;
    logic              held_valid_reg, held_valid_next;
    logic              held_half_reg, held_half_next;
    logic [31:0]       waddr_reg;
    logic [31:0]       total_reg;
    plan_t             plan_reg, plan_next;

    // Request and block write working registers.
    logic [1:0]        op_reg;
    logic [7:0]        rx_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [WW-1:0]     w_reg;
    logic [1:0]        k_reg;
    logic [31:0]       word_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [1:0]             out_kind_reg;
    logic                   out_last_reg;

    // Block store ports.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    logic              init_xfer;
    logic              do_start, do_packet;
    logic [3:0]        try_src;
    logic              expired;
    logic              comp_ok;
    logic [SUM_W-1:0]  wr_sum;
    logic [SUM_W-1:0]  scan_sum;
    logic [POS_W-1:0]  pos;
    logic              wr_go;
    logic [32:0]       total_sum;
    logic [31:0]       total_new;
    logic              emit_last;
    logic [7:0]        emit_byte;

    xcr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_base_reg   <= 32'd0;
            start_wait_reg   <= 16'd3000;
            body_wait_reg    <= 16'd500;
            packet_wait_reg  <= 16'd5000;
            tail_wait_reg    <= 16'd1000;
            start_tries_reg  <= 4'd3;
            packet_tries_reg <= 4'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLASH_BASE:   flash_base_reg   <= cfg_data;
                CFG_START_WAIT:   start_wait_reg   <= cfg_data[15:0];
                CFG_BODY_WAIT:    body_wait_reg    <= cfg_data[15:0];
                CFG_PACKET_WAIT:  packet_wait_reg  <= cfg_data[15:0];
                CFG_TAIL_WAIT:    tail_wait_reg    <= cfg_data[15:0];
                CFG_START_TRIES:  start_tries_reg  <= cfg_data[3:0];
                CFG_PACKET_TRIES: packet_tries_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign expired = (timer_reg <= 16'd1);
    assign comp_ok = ((bnum_reg + bcomp_reg) == 8'hFF);

    // Evaluation of one request against the protocol state.
    always_comb
    begin
        phase_next      = phase_reg;
        tries_next      = tries_reg;
        timer_next      = timer_reg;
        bidx_next       = bidx_reg;
        from_start_next = from_start_reg;
        exp_next        = exp_reg;
        bnum_next       = bnum_reg;
        bcomp_next      = bcomp_reg;
        crc_next        = crc_reg;
        crcrx_next      = crcrx_reg;
        held_valid_next = held_valid_reg;
        held_half_next  = held_half_reg;
        plan_next       = '0;
        init_xfer       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        do_start        = 1'b0;
        do_packet       = 1'b0;
        try_src         = tries_reg;

        if (cmd.eval)
        begin
            if (op_reg == OP_START)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    exp_next        = 8'd1;
                    held_valid_next = 1'b0;
                    init_xfer       = 1'b1;
                    try_src         = start_tries_reg;
                    do_start        = 1'b1;
                end
            end
            else if (op_reg == OP_BYTE || op_reg == OP_TICK)
            begin
                if (op_reg == OP_TICK && phase_reg != PH_IDLE)
                begin
                    timer_next = expired ? 16'd0 : timer_reg - 16'd1;
                end
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_START:
                    begin
                        if (op_reg == OP_TICK)
                        begin
                            do_start = expired;
                        end
                        else if (rx_reg == CH_SOH)
                        begin
                            from_start_next = 1'b1;
                            bidx_next       = '0;
                            timer_next      = body_wait_reg;
                            phase_next      = PH_BODY;
                        end
                        else if (rx_reg == CH_EOT)
                        begin
                            plan_next.tx_a_en    = 1'b1;
                            plan_next.tx_a       = CH_ACK;
                            plan_next.fin_en     = 1'b1;
                            plan_next.fin_status = ST_COMPLETE;
                            phase_next           = PH_IDLE;
                        end
                        else
                        begin
                            do_start = 1'b1;
                        end
                    end
                    PH_BODY:
                    begin
                        if (op_reg == OP_TICK)
                        begin
                            if (expired)
                            begin
                                plan_next.tx_a_en = 1'b1;
                                plan_next.tx_a    = CH_NAK;
                                do_start          = from_start_reg;
                                do_packet         = !from_start_reg;
                            end
                        end
                        else if (bidx_reg == BI_W'(0))
                        begin
                            bnum_next = rx_reg;
                            crc_next  = 16'd0;
                            bidx_next = bidx_reg + BI_W'(1);
                        end
                        else if (bidx_reg == BI_W'(1))
                        begin
                            bcomp_next = rx_reg;
                            bidx_next  = bidx_reg + BI_W'(1);
                        end
                        else if (bidx_reg < BI_W'(BLOCK_BYTES + 2))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'((held_half_reg ? SUM_W'(0) : SUM_W'(BLOCK_BYTES))
                                        + SUM_W'(bidx_reg - BI_W'(2)));
                            crc_next  = crc_byte(crc_reg, rx_reg);
                            bidx_next = bidx_reg + BI_W'(1);
                        end
                        else if (bidx_reg == BI_W'(BLOCK_BYTES + 2))
                        begin
                            crcrx_next = {rx_reg, 8'h00};
                            bidx_next  = bidx_reg + BI_W'(1);
                        end
                        else
                        begin
                            // Packet complete: check number, complement and CRC.
                            crcrx_next = {crcrx_reg[15:8], rx_reg};
                            bidx_next  = '0;
                            plan_next.tx_b_en = 1'b1;
                            if (bnum_reg != exp_reg || !comp_ok)
                            begin
                                plan_next.tx_b = (comp_ok && bnum_reg == exp_reg - 8'd1)
                                                 ? CH_ACK : CH_NAK;
                            end
                            else if (crc_reg != {crcrx_reg[15:8], rx_reg})
                            begin
                                plan_next.tx_b = CH_NAK;
                            end
                            else
                            begin
                                plan_next.wr_en   = held_valid_reg;
                                plan_next.wr_half = held_half_reg;
                                held_half_next    = !held_half_reg;
                                held_valid_next   = 1'b1;
                                plan_next.tx_b    = CH_ACK;
                                exp_next          = exp_reg + 8'd1;
                            end
                            try_src   = packet_tries_reg;
                            do_packet = 1'b1;
                        end
                    end
                    PH_PACKET:
                    begin
                        if (op_reg == OP_TICK)
                        begin
                            if (expired)
                            begin
                                plan_next.tx_a_en = 1'b1;
                                plan_next.tx_a    = CH_NAK;
                                do_packet         = 1'b1;
                            end
                        end
                        else if (rx_reg == CH_EOT)
                        begin
                            plan_next.tx_a_en = 1'b1;
                            plan_next.tx_a    = CH_ACK;
                            if (held_valid_reg)
                            begin
                                plan_next.wr_en   = 1'b1;
                                plan_next.scan_en = 1'b1;
                                plan_next.wr_half = held_half_reg;
                            end
                            held_valid_next = 1'b0;
                            timer_next      = tail_wait_reg;
                            phase_next      = PH_TAIL_EOT;
                        end
                        else if (rx_reg == CH_CAN)
                        begin
                            timer_next = tail_wait_reg;
                            phase_next = PH_TAIL_CAN;
                        end
                        else if (rx_reg == CH_SOH)
                        begin
                            from_start_next = 1'b0;
                            bidx_next       = '0;
                            timer_next      = body_wait_reg;
                            phase_next      = PH_BODY;
                        end
                        else
                        begin
                            do_packet = 1'b1;
                        end
                    end
                    PH_TAIL_EOT:
                    begin
                        if (op_reg == OP_TICK)
                        begin
                            if (expired)
                            begin
                                plan_next.fin_en     = 1'b1;
                                plan_next.fin_status = ST_COMPLETE;
                                phase_next           = PH_IDLE;
                            end
                        end
                        else
                        begin
                            plan_next.tx_a_en    = (rx_reg == CH_EOT);
                            plan_next.tx_a       = CH_ACK;
                            plan_next.fin_en     = 1'b1;
                            plan_next.fin_status = ST_COMPLETE;
                            phase_next           = PH_IDLE;
                        end
                    end
                    PH_TAIL_CAN:
                    begin
                        if (op_reg == OP_TICK)
                        begin
                            do_packet = expired;
                        end
                        else if (rx_reg == CH_CAN)
                        begin
                            plan_next.tx_a_en    = 1'b1;
                            plan_next.tx_a       = CH_CAN;
                            plan_next.tx_b_en    = 1'b1;
                            plan_next.tx_b       = CH_CAN;
                            plan_next.fin_en     = 1'b1;
                            plan_next.fin_status = ST_CANCELLED;
                            phase_next           = PH_IDLE;
                        end
                        else
                        begin
                            do_packet = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            // A new try of the start phase or of the packet wait.
            if (do_start)
            begin
                if (try_src == 4'd0)
                begin
                    plan_next.fin_en     = 1'b1;
                    plan_next.fin_status = ST_START_ERR;
                    phase_next           = PH_IDLE;
                end
                else
                begin
                    tries_next        = try_src - 4'd1;
                    plan_next.tx_c_en = 1'b1;
                    plan_next.tx_c    = CH_C;
                    timer_next        = start_wait_reg;
                    phase_next        = PH_START;
                end
            end
            if (do_packet)
            begin
                if (try_src == 4'd0)
                begin
                    plan_next.fin_en     = 1'b1;
                    plan_next.fin_status = ST_TIMEOUT;
                    phase_next           = PH_IDLE;
                end
                else
                begin
                    tries_next = try_src - 4'd1;
                    timer_next = packet_wait_reg;
                    phase_next = PH_PACKET;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tries_reg      <= 4'd0;
            timer_reg      <= 16'd0;
            bidx_reg       <= '0;
            from_start_reg <= 1'b0;
            exp_reg        <= 8'd1;
            bnum_reg       <= 8'd0;
            bcomp_reg      <= 8'd0;
            crc_reg        <= 16'd0;
            crcrx_reg      <= 16'd0;
            held_valid_reg <= 1'b0;
            held_half_reg  <= 1'b0;
            plan_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tries_reg      <= tries_next;
            timer_reg      <= timer_next;
            bidx_reg       <= bidx_next;
            from_start_reg <= from_start_next;
            exp_reg        <= exp_next;
            bnum_reg       <= bnum_next;
            bcomp_reg      <= bcomp_next;
            crc_reg        <= crc_next;
            crcrx_reg      <= crcrx_next;
            held_valid_reg <= held_valid_next;
            held_half_reg  <= held_half_next;
            if (cmd.eval)
            begin
                plan_reg <= plan_next;
            end
        end
    end

    // Request capture, trim length and word assembly.
    assign pos      = {w_reg, k_reg};
    assign wr_sum   = (plan_reg.wr_half ? SUM_W'(BLOCK_BYTES) : SUM_W'(0)) + SUM_W'(pos);
    assign scan_sum = (plan_reg.wr_half ? SUM_W'(BLOCK_BYTES) : SUM_W'(0))
                      + SUM_W'(len_reg) - SUM_W'(1);

    always_comb
    begin
        if (cmd.scan_rd)
        begin
            ram_raddr = AW'(scan_sum);
        end
        else if (wr_sum >= SUM_W'(DEPTH))
        begin
            ram_raddr = AW'(wr_sum - SUM_W'(DEPTH));
        end
        else
        begin
            ram_raddr = AW'(wr_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= s_tuser;
            rx_reg <= s_tdata[7:0];
        end
        if (cmd.eval)
        begin
            len_reg <= LEN_W'(BLOCK_BYTES);
            w_reg   <= '0;
            k_reg   <= 2'd0;
        end
        else
        begin
            if (cmd.len_dec)
            begin
                len_reg <= len_reg - LEN_W'(1);
            end
            if (cmd.wr_get)
            begin
                word_reg <= {(CMP_W'(pos) < CMP_W'(len_reg)) ? ram_rdata : CH_ERASED,
                             word_reg[31:8]};
                k_reg    <= k_reg + 2'd1;
            end
            if (cmd.emit == EM_WORD)
            begin
                w_reg <= w_reg + WW'(1);
            end
        end
    end

    // Flash address and byte total.
    assign total_sum = {1'b0, total_reg} + 33'(len_reg);
    assign total_new = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waddr_reg <= 32'd0;
            total_reg <= 32'd0;
        end
        else
        begin
            if (init_xfer)
            begin
                waddr_reg <= flash_base_reg;
                total_reg <= 32'd0;
            end
            else
            begin
                if (cmd.emit == EM_WORD)
                begin
                    waddr_reg <= waddr_reg + 32'd4;
                end
                if (cmd.total_add)
                begin
                    total_reg <= total_new;
                end
            end
        end
    end

    // Output register.
    assign wr_go = plan_reg.wr_en && (len_reg != '0);

    always_comb
    begin
        emit_last = 1'b0;
        emit_byte = 8'h00;
        unique case (cmd.emit)
            EM_NONE: ;
            EM_TXA:
            begin
                emit_byte = plan_reg.tx_a;
                emit_last = !(wr_go || plan_reg.tx_b_en || plan_reg.tx_c_en
                              || plan_reg.fin_en);
            end
            EM_WORD:
            begin
                emit_last = st.w_last && !(plan_reg.tx_b_en || plan_reg.tx_c_en
                                           || plan_reg.fin_en);
            end
            EM_TXB:
            begin
                emit_byte = plan_reg.tx_b;
                emit_last = !(plan_reg.tx_c_en || plan_reg.fin_en);
            end
            EM_TXC:
            begin
                emit_byte = plan_reg.tx_c;
                emit_last = !plan_reg.fin_en;
            end
            EM_FIN:  emit_last = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit != EM_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != EM_NONE)
        begin
            out_last_reg <= emit_last;
            unique case (cmd.emit)
                EM_WORD:
                begin
                    out_kind_reg <= KIND_FLASH;
                    out_data_reg <= {6'd0, 32'd0, 2'd0, word_reg, waddr_reg, 8'd0};
                end
                EM_FIN:
                begin
                    out_kind_reg <= KIND_DONE;
                    out_data_reg <= {6'd0, total_reg, plan_reg.fin_status, 32'd0,
                                     32'd0, 8'd0};
                end
                default:
                begin
                    out_kind_reg <= KIND_TX;
                    out_data_reg <= {6'd0, 32'd0, 2'd0, 32'd0, 32'd0, emit_byte};
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign st.scan_en  = plan_reg.scan_en;
    assign st.tx_a_en  = plan_reg.tx_a_en;
    assign st.wr_go    = wr_go;
    assign st.tx_b_en  = plan_reg.tx_b_en;
    assign st.tx_c_en  = plan_reg.tx_c_en;
    assign st.fin_en   = plan_reg.fin_en;
    assign st.len_zero = (len_reg == '0);
    assign st.rd_pad   = (ram_rdata == CH_PAD);
    assign st.k_last   = (k_reg == 2'd3);
    assign st.w_last   = (w_reg == WW'(WORDS - 1));
    assign st.out_free = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

/* sv/xmodem_crc_receiver_unit.sv */
// ----------------------------------------------------------------------------
// xmodem_crc_receiver_unit
// XMODEM-CRC receiver: start, received bytes and millisecond ticks in;
// reply bytes, flash word writes and a final status out.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Content
//  s_*      in         s_tvalid / s_tready  tuser: operation, tdata: rx_byte
//  m_*      out        m_tvalid / m_tready  tuser: kind, tdata: result fields,
//                                           tlast: last result of a request
//  cfg_*    in         cfg_we               register index and write data
//
// One request is handled at a time. A request that writes a block emits
// WORDS flash words (WORDS = BLOCK_BYTES/4, rounded up), each gathered
// byte by byte through the byte-wide read port of the block store; at EOT
// a trim scan first reads the held block back from its end, one trailing
// pad byte at a time, to find its length. Reset is asynchronous and clears
// the protocol state and the configuration to its default values; the
// block store is not cleared. While m_tready is low, a further result of
// the same request waits in the sequencer, and no new request is taken
// until that result has moved into the output register.
//
`default_nettype none

module xmodem_crc_receiver_unit
    import xcr_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_data,
    // Request stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]             s_tuser,   // [1:0] operation
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [7:0] tx_byte,
                                                   // [39:8] flash_address,
                                                   // [71:40] flash_word,
                                                   // [73:72] status,
                                                   // [105:74] byte_count
    output logic [1:0]                  m_tuser,   // [1:0] kind
    output logic                        m_tlast    // last_of_run
);

    dp_cmd_t    cmd;
    dp_status_t st;

    // The sequencer steps through each request's results in order.
    xcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the protocol state, the two block halves and
    // the output register.
    xcr_dp #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

/* bench/xmodem_crc_receiver_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xmodem_crc_receiver_unit_test
// Self-checking bench for the XMODEM-CRC receiver. Whole transfers (start,
// packets with random content, flaws, timeouts, EOT and CAN endings) are
// streamed in, and every reply byte, flash word and final status is compared
// with a cycle-free model of the receiver kept inside this bench.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_crc_receiver_unit_test;
    import xcr_pkg::*;

    localparam int BLK       = 128;
    localparam int LIMIT     = 3000000;
    localparam int SETTLE    = 700;
    localparam int HOLD_LEN  = 400;
    localparam int ITEMS     = 200;

    // Operation code that the receiver ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One request: operation in tuser, received byte in tdata.
    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
    } request_t;

    // One result, field by field.
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [31:0] addr;
        logic [31:0] word;
        logic [1:0]  status;
        logic [31:0] count;
        logic        last;
    } result_t;

    // Ways in which a generated packet can be damaged.
    typedef enum int {
        FL_GOOD,
        FL_CRC,
        FL_COMP,
        FL_NUM,
        FL_SHORT
    } flaw_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;     // [7:0] rx_byte
    logic [1:0]   s_tuser = '0;     // [1:0] operation
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;          // tx_byte, flash_address, flash_word,
                                    // status, byte_count from bit 0 up
    logic [1:0]   m_tuser;          // [1:0] kind
    logic         m_tlast;

    xmodem_crc_receiver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Requests waiting to be offered, and results the receiver owes us.
    request_t pending_q[$];
    result_t  owed_q[$];

    int  errors = 0;
    int  cycles = 0;
    int  gap = 0;
    int  stall = 0;
    int  hold_cnt = 0;
    int  n_put = 0;
    bit  hold_go = 1'b0;
    bit  calm = 1'b0;

    // ------------------------------------------------------------------
    // Receiver model: configuration copy and protocol state.
    // ------------------------------------------------------------------
    logic [31:0] c_base;
    logic [15:0] c_swait, c_bwait, c_pwait, c_twait;
    logic [3:0]  c_stries, c_ptries;

    phase_t      ph;
    logic [3:0]  tries;
    logic [15:0] timer;
    int          body_pos;
    bit          from_start;
    logic [7:0]  want_blk, blk_no, blk_cmp;
    logic [15:0] crc_acc, crc_rx;
    logic [7:0]  store [256];
    bit          held_v, held_h;
    logic [31:0] waddr, total;

    // CRC16-CCITT, one byte, worked bit by bit from the top.
    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ 16'h1021;
            end
        end
        return c;
    endfunction

    function automatic void owe(logic [1:0] k, logic [7:0] tx, logic [31:0] a,
                                logic [31:0] w, logic [1:0] st, logic [31:0] n);
        result_t r;
        r.kind = k;
        r.tx = tx;
        r.addr = a;
        r.word = w;
        r.status = st;
        r.count = n;
        r.last = 1'b0;
        owed_q.push_back(r);
    endfunction

    function automatic void reply(logic [7:0] b);
        owe(KIND_TX, b, '0, '0, '0, '0);
    endfunction

    function automatic void finish_xfer(logic [1:0] st);
        owe(KIND_DONE, '0, '0, '0, st, total);
        ph = PH_IDLE;
    endfunction

    function automatic bit timer_out();
        if (timer <= 16'd1)
        begin
            timer = '0;
            return 1'b1;
        end
        timer = timer - 16'd1;
        return 1'b0;
    endfunction

    function automatic void start_retry();
        if (tries == 0)
        begin
            finish_xfer(ST_START_ERR);
            return;
        end
        tries = tries - 4'd1;
        reply(CH_C);
        timer = c_swait;
        ph = PH_START;
    endfunction

    function automatic void packet_retry();
        if (tries == 0)
        begin
            finish_xfer(ST_TIMEOUT);
            return;
        end
        tries = tries - 4'd1;
        timer = c_pwait;
        ph = PH_PACKET;
    endfunction

    // Writes one stored block as flash words; bytes past len read as erased.
    function automatic void flush_block(bit half, int len);
        logic [31:0] word;
        logic [7:0]  b;
        logic [32:0] sum;
        for (int w = 0; w < BLK / 4; w++)
        begin
            word = '0;
            for (int k = 0; k < 4; k++)
            begin
                b = (w * 4 + k < len) ? store[{half, 7'(w * 4 + k)}] : CH_ERASED;
                word = word | (32'(b) << (8 * k));
            end
            owe(KIND_FLASH, '0, waddr, word, '0, '0);
            waddr = waddr + 32'd4;
        end
        sum = {1'b0, total} + 33'(len);
        total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void packet_end();
        bit comp_ok;
        comp_ok = (8'(blk_no + blk_cmp) == 8'hFF);
        if (blk_no != want_blk || !comp_ok)
        begin
            // A correct repeat of the previous block is acknowledged only.
            if (comp_ok && blk_no == 8'(want_blk - 8'd1))
            begin
                reply(CH_ACK);
            end
            else
            begin
                reply(CH_NAK);
            end
        end
        else if (crc_acc != crc_rx)
        begin
            reply(CH_NAK);
        end
        else
        begin
            if (held_v)
            begin
                flush_block(held_h, BLK);
            end
            held_h = ~held_h;
            held_v = 1'b1;
            reply(CH_ACK);
            want_blk = want_blk + 8'd1;
        end
        tries = c_ptries;
        packet_retry();
    endfunction

    function automatic void body_in(logic [7:0] b);
        if (body_pos == 0)
        begin
            blk_no = b;
            crc_acc = '0;
        end
        else if (body_pos == 1)
        begin
            blk_cmp = b;
        end
        else if (body_pos < BLK + 2)
        begin
            store[{~held_h, 7'(body_pos - 2)}] = b;
            crc_acc = crc_step(crc_acc, b);
        end
        else if (body_pos == BLK + 2)
        begin
            crc_rx = {b, 8'h00};
        end
        else
        begin
            crc_rx[7:0] = b;
            body_pos = 0;
            packet_end();
            return;
        end
        body_pos++;
    endfunction

    function automatic void enter_body(bit fs);
        from_start = fs;
        body_pos = 0;
        timer = c_bwait;
        ph = PH_BODY;
    endfunction

    // EOT: the held block loses its trailing pad bytes before it is written.
    function automatic void end_of_file();
        int len;
        reply(CH_ACK);
        if (held_v)
        begin
            len = BLK;
            while (len > 0 && store[{held_h, 7'(len - 1)}] == CH_PAD)
            begin
                len--;
            end
            if (len > 0)
            begin
                flush_block(held_h, len);
            end
            held_v = 1'b0;
        end
        timer = c_twait;
        ph = PH_TAIL_EOT;
    endfunction

    // Works out every result one accepted request causes.
    function automatic void predict(logic [1:0] op, logic [7:0] b);
        int      n0;
        bit      tick;
        result_t r;
        n0 = owed_q.size();
        tick = (op == OP_TICK);
        if (op == OP_START)
        begin
            if (ph == PH_IDLE)
            begin
                want_blk = 8'd1;
                held_v = 1'b0;
                total = '0;
                waddr = c_base;
                tries = c_stries;
                start_retry();
            end
        end
        else if (op == OP_BYTE || tick)
        begin
            case (ph)
                PH_START:
                begin
                    if (tick)
                    begin
                        if (timer_out()) start_retry();
                    end
                    else if (b == CH_SOH)
                    begin
                        enter_body(1'b1);
                    end
                    else if (b == CH_EOT)
                    begin
                        reply(CH_ACK);
                        finish_xfer(ST_COMPLETE);
                    end
                    else
                    begin
                        start_retry();
                    end
                end
                PH_BODY:
                begin
                    if (tick)
                    begin
                        if (timer_out())
                        begin
                            reply(CH_NAK);
                            if (from_start) start_retry();
                            else packet_retry();
                        end
                    end
                    else
                    begin
                        body_in(b);
                    end
                end
                PH_PACKET:
                begin
                    if (tick)
                    begin
                        if (timer_out())
                        begin
                            reply(CH_NAK);
                            packet_retry();
                        end
                    end
                    else if (b == CH_EOT)
                    begin
                        end_of_file();
                    end
                    else if (b == CH_CAN)
                    begin
                        timer = c_twait;
                        ph = PH_TAIL_CAN;
                    end
                    else if (b == CH_SOH)
                    begin
                        enter_body(1'b0);
                    end
                    else
                    begin
                        packet_retry();
                    end
                end
                PH_TAIL_EOT:
                begin
                    if (tick)
                    begin
                        if (timer_out()) finish_xfer(ST_COMPLETE);
                    end
                    else
                    begin
                        if (b == CH_EOT) reply(CH_ACK);
                        finish_xfer(ST_COMPLETE);
                    end
                end
                PH_TAIL_CAN:
                begin
                    if (tick)
                    begin
                        if (timer_out()) packet_retry();
                    end
                    else if (b == CH_CAN)
                    begin
                        reply(CH_CAN);
                        reply(CH_CAN);
                        finish_xfer(ST_CANCELLED);
                    end
                    else
                    begin
                        packet_retry();
                    end
                end
                default:
                begin
                end
            endcase
        end
        // Mark the last result of this request.
        if (owed_q.size() > n0)
        begin
            r = owed_q.pop_back();
            r.last = 1'b1;
            owed_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver. A request is taken when s_tvalid and s_tready meet at
    // a rising edge; the model runs right there. After each request a random
    // gap, possibly none, is drawn, except in calm stretches. When no gap
    // is drawn the next request follows without lowering s_tvalid.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int       wait_n;
        request_t q;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict(s_tuser, s_tdata);
                wait_n = calm ? 0 : $urandom_range(0, 4);
            end
            else if (!s_tvalid && gap != 0)
            begin
                wait_n = gap - 1;
            end
            else
            begin
                wait_n = gap;
            end
            if ((!s_tvalid || s_tready) && wait_n == 0 && pending_q.size() != 0)
            begin
                q = pending_q.pop_front();
                s_tuser <= q.op;
                s_tdata <= q.data;
                s_tvalid <= 1'b1;
                gap <= 0;
            end
            else
            begin
                if (s_tvalid && s_tready)
                begin
                    s_tvalid <= 1'b0;
                end
                gap <= wait_n;
            end
        end
    end

    // Long hold-off of the result side, counted here so that the driver keeps
    // offering requests while the receiver backs up.
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_cnt <= HOLD_LEN;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                     want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: each accepted result is checked against the oldest
    // owed one; a random stall, possibly none, is drawn after each result.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        int      hold_n;
        result_t w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %h data %h",
                             $time, m_tuser, m_tdata);
                    errors++;
                end
                else
                begin
                    w = owed_q.pop_front();
                    check_field("kind", 32'(w.kind), 32'(m_tuser));
                    check_field("tx_byte", 32'(w.tx), 32'(m_tdata[7:0]));
                    check_field("flash_address", w.addr, m_tdata[39:8]);
                    check_field("flash_word", w.word, m_tdata[71:40]);
                    check_field("status", 32'(w.status), 32'(m_tdata[73:72]));
                    check_field("byte_count", w.count, m_tdata[105:74]);
                    check_field("last", 32'(w.last), 32'(m_tlast));
                end
                hold_n = calm ? 0 : $urandom_range(0, 4);
            end
            else if (stall != 0)
            begin
                hold_n = stall - 1;
            end
            else
            begin
                hold_n = 0;
            end
            stall <= hold_n;
            m_tready <= (hold_n == 0) && (hold_cnt == 0);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("xmodem_crc_receiver_unit_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------
    task automatic put(logic [1:0] op, logic [7:0] b);
        request_t q;
        q.op = op;
        q.data = b;
        pending_q.push_back(q);
        n_put++;
    endtask

    task automatic put_ticks(int n);
        repeat (n) put(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // A byte that is not one of the framing characters.
    function automatic logic [7:0] junk_byte();
        logic [7:0] r;
        do
        begin
            r = 8'($urandom_range(0, 255));
        end
        while (r == CH_SOH || r == CH_EOT || r == CH_CAN);
        return r;
    endfunction

    function automatic int ticks_of(logic [15:0] w);
        return (w == 0) ? 1 : int'(w);
    endfunction

    // One packet: SOH, number, complement, 128 data bytes, CRC high first.
    task automatic send_block(logic [7:0] num, flaw_t flaw);
        logic [7:0]  data [BLK];
        logic [7:0]  n, cmp, b;
        logic [15:0] crc;
        int          style, pad_from, stop;
        style = $urandom_range(0, 5);
        pad_from = (style == 1) ? $urandom_range(1, BLK - 1) : (style == 2) ? 0 : BLK;
        crc = '0;
        for (int i = 0; i < BLK; i++)
        begin
            data[i] = (style == 3) ? 8'hFF : (style == 4) ? 8'h00
                      : 8'($urandom_range(0, 255));
            if (i >= pad_from)
            begin
                data[i] = CH_PAD;
            end
            crc = crc_step(crc, data[i]);
        end
        n = (flaw == FL_NUM) ? num ^ (8'd1 << $urandom_range(0, 7)) : num;
        cmp = ~n;
        if (flaw == FL_COMP)
        begin
            cmp = cmp ^ (8'd1 << $urandom_range(0, 7));
        end
        if (flaw == FL_CRC)
        begin
            crc = crc ^ (16'd1 << $urandom_range(0, 15));
        end
        stop = (flaw == FL_SHORT) ? $urandom_range(0, BLK + 3) : BLK + 4;
        put(OP_BYTE, CH_SOH);
        for (int j = 0; j < stop; j++)
        begin
            b = (j == 0) ? n : (j == 1) ? cmp : (j == BLK + 2) ? crc[15:8]
                : (j == BLK + 3) ? crc[7:0] : data[j - 2];
            put(OP_BYTE, b);
        end
        if (flaw == FL_SHORT)
        begin
            put_ticks(ticks_of(c_bwait));
        end
    endtask

    // A whole transfer: mostly well formed, with a random flaw here and there.
    // Packets are sent only if one more packet fits in the ITEMS request target.
    task automatic send_transfer();
        logic [7:0] blk;
        int         npk, r;
        put(OP_START, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
        begin
            put(OP_BYTE, junk_byte());
        end
        if (c_swait <= 8 && $urandom_range(0, 5) == 0)
        begin
            put_ticks(ticks_of(c_swait));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            put(OP_UNUSED, 8'($urandom_range(0, 255)));
        end
        npk = (n_put + BLK + 6 > ITEMS) ? 0 : $urandom_range(0, 3);
        blk = 8'd1;
        for (int i = 0; i < npk; i++)
        begin
            r = $urandom_range(0, 13);
            case (r)
                0: send_block(blk, FL_CRC);
                1: send_block(blk, FL_COMP);
                2: send_block(blk, FL_NUM);
                3: if (c_bwait <= 8) send_block(blk, FL_SHORT);
                4: if (blk != 8'd1) send_block(blk - 8'd1, FL_GOOD);
                5: put(OP_BYTE, junk_byte());
                6:
                begin
                    // Single CAN, then a stray byte that is dropped.
                    put(OP_BYTE, CH_CAN);
                    put(OP_BYTE, junk_byte());
                end
                7: if (c_pwait <= 8) put_ticks(ticks_of(c_pwait));
                8: put(OP_START, 8'h00);
                default:
                begin
                end
            endcase
            send_block(blk, FL_GOOD);
            blk = blk + 8'd1;
        end
        r = $urandom_range(0, 5);
        case (r)
            0:
            begin
                put(OP_BYTE, CH_EOT);
                put(OP_BYTE, junk_byte());
            end
            1:
            begin
                put(OP_BYTE, CH_EOT);
                if (c_twait <= 8) put_ticks(ticks_of(c_twait));
                else put(OP_BYTE, CH_EOT);
            end
            2:
            begin
                put(OP_BYTE, CH_CAN);
                put(OP_BYTE, CH_CAN);
            end
            3:
            begin
                if (c_pwait <= 8)
                begin
                    put_ticks(ticks_of(c_pwait) * (int'(c_ptries) + 1));
                end
                else
                begin
                    put(OP_BYTE, CH_CAN);
                    put(OP_BYTE, CH_CAN);
                end
            end
            default:
            begin
                put(OP_BYTE, CH_EOT);
                put(OP_BYTE, CH_EOT);
            end
        endcase
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_FLASH_BASE:   c_base = val;
            CFG_START_WAIT:   c_swait = val[15:0];
            CFG_BODY_WAIT:    c_bwait = val[15:0];
            CFG_PACKET_WAIT:  c_pwait = val[15:0];
            CFG_TAIL_WAIT:    c_twait = val[15:0];
            CFG_START_TRIES:  c_stries = val[3:0];
            CFG_PACKET_TRIES: c_ptries = val[3:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every request is taken and every result has come back,
    // then gives the longest block write plus a trim scan time to finish.
    task automatic drain();
        while (pending_q.size() != 0 || s_tvalid || owed_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(logic [31:0] base, logic [15:0] sw, logic [15:0] bw,
                             logic [15:0] pw, logic [15:0] tw, logic [3:0] st,
                             logic [3:0] pt, int xfers, bit quiet, bit hold);
        cfg_write(CFG_FLASH_BASE, base);
        cfg_write(CFG_START_WAIT, 32'(sw));
        cfg_write(CFG_BODY_WAIT, 32'(bw));
        cfg_write(CFG_PACKET_WAIT, 32'(pw));
        cfg_write(CFG_TAIL_WAIT, 32'(tw));
        cfg_write(CFG_START_TRIES, 32'(st));
        cfg_write(CFG_PACKET_TRIES, 32'(pt));
        calm = quiet;
        repeat (xfers) send_transfer();
        if (hold)
        begin
            @(posedge clk);
            hold_go <= 1'b1;
            @(posedge clk);
            hold_go <= 1'b0;
        end
        drain();
    endtask

    initial
    begin
        // Model state after reset; the configuration takes its defaults.
        c_base = '0;
        c_swait = 16'd3000;
        c_bwait = 16'd500;
        c_pwait = 16'd5000;
        c_twait = 16'd1000;
        c_stries = 4'd3;
        c_ptries = 4'd10;
        ph = PH_IDLE;
        tries = '0;
        timer = '0;
        body_pos = 0;
        from_start = 1'b0;
        want_blk = 8'd1;
        blk_no = '0;
        blk_cmp = '0;
        crc_acc = '0;
        crc_rx = '0;
        held_v = 1'b0;
        held_h = 1'b0;
        waddr = '0;
        total = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening at the reset configuration: ignored operation,
        // bytes and ticks while idle, EOT right after start, a repeated start
        // while busy, a stray byte in the start phase, then two good blocks
        // (the first is written when the second arrives) closed by two EOTs.
        put(OP_UNUSED, 8'hFF);
        put(OP_BYTE, 8'hFF);
        put(OP_TICK, 8'h00);
        put(OP_START, 8'h00);
        put(OP_BYTE, CH_EOT);
        put(OP_START, 8'h00);
        put(OP_START, 8'hFF);
        put(OP_BYTE, 8'h00);
        send_block(8'd1, FL_GOOD);
        send_block(8'd2, FL_GOOD);
        put(OP_BYTE, CH_EOT);
        put(OP_BYTE, CH_EOT);
        drain();

        // Waits and tries of one, with a base near the top of the address range.
        run_phase(32'hFFFF_FFF0, 16'd1, 16'd1, 16'd1, 16'd1, 4'd1, 4'd1, 1, 0, 0);
        // Zero waits and zero tries: the start fails at once.
        run_phase($urandom, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 4'd0, 1, 0, 0);
        // Zero packet tries.
        run_phase($urandom, 16'd0, 16'd0, 16'd0, 16'd0, 4'd15, 4'd0, 1, 0, 0);
        // Largest waits and tries.
        run_phase(32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 1, 0, 0);
        // Mid-range settings; the result side is held off for a long time.
        run_phase($urandom, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                  4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)), 2, 0, 1);
        // Same kind of settings with no idling on either side.
        run_phase($urandom, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                  4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)), 1, 1, 0);
        run_phase($urandom, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                  4'($urandom_range(2, 6)), 4'($urandom_range(2, 6)), 1, 0, 0);

        if (errors == 0)
        begin
            $display("xmodem_crc_receiver_unit_test: PASS");
        end
        else
        begin
            $display("xmodem_crc_receiver_unit_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
